// File: hw/rtl/itaf_pkg.sv
package itaf_pkg;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 8;
  localparam int unsigned KindW     = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned BufDepth  = 11;
  localparam int unsigned CntW      = 4;

  localparam logic [KindW-1:0] KIND_CHAR = 3'd0;
  localparam logic [KindW-1:0] KIND_UDEC = 3'd1;
  localparam logic [KindW-1:0] KIND_SDEC = 3'd2;
  localparam logic [KindW-1:0] KIND_OCT  = 3'd3;
  localparam logic [KindW-1:0] KIND_HEX  = 3'd4;

  // ceil(2^35 / 10): exact divide by ten for every 32-bit value
  localparam logic [ValueW-1:0] RECIP10 = 32'hCCCC_CCCD;

  localparam logic [15:0][CharW-1:0] DIGIT_SET  = "FEDCBA9876543210";
  localparam logic [4:0][CharW-1:0]  HELLO_TEXT = "ollEH";
  localparam logic [CharW-1:0]       MINUS_CHAR = 8'h2D;

  typedef struct packed {
    logic load;
    logic mul;
    logic dig;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic start_digits;
    logic conv_done;
    logic out_free;
    logic emit_last;
  } dp_status_t;

endpackage

// File: hw/rtl/integer_to_ascii_formatter_unit.sv
// Integer to ASCII formatter.
// Slave stream: one request per transfer, tdata = {pad, value[31:0], kind[2:0]}.
//   kind: 0 char, 1 unsigned dec, 2 signed dec, 3 octal, 4 upper hex, else "HEllo".
// Master stream: one ASCII character per transfer in tdata[7:0], most significant
//   digit first; tlast marks the final character of the request (1 to 11 chars).
// Requests are handled one at a time; tready is high only while idle.
// Digit kinds form each digit in a quotient step (reciprocal multiply for
//   divide by ten, registered), then a remainder step.
// The first character is registered in the emit state, which follows the digit
//   loop (and follows accept directly for char and unknown kinds).
// A single output register sits on the master side; a new request is accepted
//   while the final character still waits there. When the receiver stalls,
//   emission pauses and the held character stays stable.
// Reset clears the controller and the output valid; no request or character
//   is in flight afterwards.
module integer_to_ascii_formatter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [itaf_pkg::InTdataW-1:0]   s_axis_tdata_i,  // kind[2:0], value[34:3], zero
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [itaf_pkg::OutTdataW-1:0]  m_axis_tdata_o,  // text_char[7:0]
  output logic                            m_axis_tlast_o
);

  itaf_pkg::dp_cmd_t    cmd;
  itaf_pkg::dp_status_t status;

  itaf_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  itaf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// File: hw/rtl/itaf_ctrl.sv
module itaf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  itaf_pkg::dp_status_t status_i,
  output itaf_pkg::dp_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIG  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.start_digits ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIG;
      end
      ST_DIG: begin
        cmd_o.dig = 1'b1;
        state_d   = status_i.conv_done ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/itaf_datapath.sv
module itaf_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [itaf_pkg::InTdataW-1:0]    s_axis_tdata_i,
  input  itaf_pkg::dp_cmd_t                cmd_i,
  output itaf_pkg::dp_status_t             status_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [itaf_pkg::OutTdataW-1:0]   m_axis_tdata_o,
  output logic                             m_axis_tlast_o
);

  logic [itaf_pkg::KindW-1:0]  in_kind;
  logic [itaf_pkg::ValueW-1:0] in_value;
  logic                        in_neg;

  logic [itaf_pkg::KindW-1:0]  kind_q;
  logic [itaf_pkg::ValueW-1:0] val_q;
  logic [itaf_pkg::ValueW-1:0] quo_q;
  logic                        neg_q;
  logic [itaf_pkg::CntW-1:0]   cnt_q;
  logic [itaf_pkg::CharW-1:0]  buf_q [itaf_pkg::BufDepth];

  logic [itaf_pkg::CharW-1:0]  out_data_q;
  logic                        out_last_q;
  logic                        out_valid_q;

  logic [2*itaf_pkg::ValueW-1:0] prod;
  logic [itaf_pkg::ValueW-1:0]   quo_d;
  logic [itaf_pkg::ValueW-1:0]   quo_times_radix;
  logic [itaf_pkg::ValueW-1:0]   rem_full;
  logic [itaf_pkg::CharW-1:0]    digit_char;
  logic [itaf_pkg::CntW-1:0]     cnt_m1;
  logic                          is_digits;
  logic [itaf_pkg::CharW-1:0]    emit_char;
  logic                          emit_last;

  assign in_kind  = s_axis_tdata_i[itaf_pkg::KindW-1:0];
  assign in_value = s_axis_tdata_i[itaf_pkg::KindW +: itaf_pkg::ValueW];
  assign in_neg   = (in_kind == itaf_pkg::KIND_SDEC) && in_value[itaf_pkg::ValueW-1];

  assign prod = {{itaf_pkg::ValueW{1'b0}}, val_q} *
                {{itaf_pkg::ValueW{1'b0}}, itaf_pkg::RECIP10};

  always_comb begin
    case (kind_q)
      itaf_pkg::KIND_OCT: begin
        quo_d           = val_q >> 3;
        quo_times_radix = quo_q << 3;
      end
      itaf_pkg::KIND_HEX: begin
        quo_d           = val_q >> 4;
        quo_times_radix = quo_q << 4;
      end
      default: begin
        quo_d           = {3'b000, prod[2*itaf_pkg::ValueW-1:35]};
        quo_times_radix = (quo_q << 3) + (quo_q << 1);
      end
    endcase
  end

  assign rem_full   = val_q - quo_times_radix;
  assign digit_char = itaf_pkg::DIGIT_SET[rem_full[3:0]];
  assign cnt_m1     = cnt_q - 4'd1;

  assign is_digits = (kind_q == itaf_pkg::KIND_UDEC) || (kind_q == itaf_pkg::KIND_SDEC) ||
                     (kind_q == itaf_pkg::KIND_OCT)  || (kind_q == itaf_pkg::KIND_HEX);

  always_comb begin
    if (kind_q == itaf_pkg::KIND_CHAR) begin
      emit_char = val_q[itaf_pkg::CharW-1:0];
      emit_last = 1'b1;
    end else if (is_digits) begin
      emit_char = neg_q ? itaf_pkg::MINUS_CHAR : buf_q[cnt_m1];
      emit_last = !neg_q && (cnt_q == 4'd1);
    end else begin
      emit_char = itaf_pkg::HELLO_TEXT[cnt_q[2:0]];
      emit_last = (cnt_q == 4'd4);
    end
  end

  assign status_o.start_digits = (in_kind == itaf_pkg::KIND_UDEC) ||
                                 (in_kind == itaf_pkg::KIND_SDEC) ||
                                 (in_kind == itaf_pkg::KIND_OCT)  ||
                                 (in_kind == itaf_pkg::KIND_HEX);
  assign status_o.conv_done    = (quo_q == '0);
  assign status_o.out_free     = !out_valid_q || m_axis_tready_i;
  assign status_o.emit_last    = emit_last;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_kind;
      val_q  <= in_neg ? (32'd0 - in_value) : in_value;
    end else if (cmd_i.dig) begin
      val_q <= quo_q;
    end
    if (cmd_i.mul) begin
      quo_q <= quo_d;
    end
    if (cmd_i.dig) begin
      buf_q[cnt_q] <= digit_char;
    end
    if (cmd_i.emit) begin
      out_data_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        neg_q <= in_neg;
        cnt_q <= '0;
      end else if (cmd_i.dig) begin
        cnt_q <= cnt_q + 4'd1;
      end else if (cmd_i.emit) begin
        if (is_digits && neg_q) begin
          neg_q <= 1'b0;
        end else if (is_digits) begin
          cnt_q <= cnt_m1;
        end else begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: hw/rtl/itaf_checker.sv
module itaf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [itaf_pkg::InTdataW-1:0]   s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [itaf_pkg::OutTdataW-1:0]  m_axis_tdata_o,
  input logic                            m_axis_tlast_o
);

  logic s_xfer;
  logic m_xfer;

  assign s_xfer = s_axis_tvalid_i && s_axis_tready_o;
  assign m_xfer = m_axis_tvalid_o && m_axis_tready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready_o)
    else $error("request accepted while previous request busy");

  a_no_req_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("ready for a request before run finished");

  a_no_xfer_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_xfer && !m_axis_tlast_o |=> !s_axis_tready_o || m_axis_tvalid_o)
    else $error("run ended without a final character");

endmodule

bind integer_to_ascii_formatter_unit itaf_checker u_itaf_checker (.*);

// File: sim/tb_integer_to_ascii_formatter_unit.sv
module tb_integer_to_ascii_formatter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import itaf_pkg::*;

  localparam logic [KindW-1:0] KIND_HELLO = 3'd5;
  localparam logic [KindW-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KindW-1:0] KIND_RSVD7 = 3'd7;
  localparam int unsigned PadW = InTdataW - KindW - ValueW;
  localparam int IdleLimit = 2000;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             last;
  } char_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 m_axis_tlast_o;

  char_item_t expected_chars[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int char_errors = 0;
  int requests_sent = 0;
  int chars_checked = 0;
  int quiet_cycles = 0;

  integer_to_ascii_formatter_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void predict_text(input logic [KindW-1:0] kind,
                                       input logic [ValueW-1:0] value);
    logic [CharW-1:0] text [BufDepth];
    logic [CharW-1:0] digits [BufDepth];
    logic [ValueW-1:0] mag;
    int unsigned radix;
    int n;
    int count;
    char_item_t item;
    count = 0;
    radix = 0;
    mag = value;
    case (kind)
      KIND_CHAR: begin
        text[0] = value[CharW-1:0];
        count = 1;
      end
      KIND_UDEC: radix = 10;
      KIND_SDEC: begin
        radix = 10;
        if (value[ValueW-1]) begin
          text[0] = MINUS_CHAR;
          count = 1;
          mag = -value;
        end
      end
      KIND_OCT: radix = 8;
      KIND_HEX: radix = 16;
      default: begin
        for (int k = 0; k < 5; k++) text[k] = HELLO_TEXT[k];
        count = 5;
      end
    endcase
    if (radix != 0) begin
      n = 0;
      do begin
        digits[n] = DIGIT_SET[mag % radix];
        mag = mag / radix;
        n++;
      end while (mag != 0);
      for (int k = n - 1; k >= 0; k--) begin
        text[count] = digits[k];
        count++;
      end
    end
    for (int k = 0; k < count; k++) begin
      item.text_char = text[k];
      item.last = (k == count - 1);
      expected_chars.push_back(item);
    end
  endfunction

  // receiver side: random stall, result check, activity tracking
  always @(posedge clk_i) begin
    char_item_t want;
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        char_errors++;
        $display("%0t: unexpected char %h last %b", $time, m_axis_tdata_o, m_axis_tlast_o);
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata_o !== want.text_char || m_axis_tlast_o !== want.last) begin
          char_errors++;
          $display("%0t: char expected %h got %h, last expected %b got %b", $time,
                   want.text_char, m_axis_tdata_o, want.last, m_axis_tlast_o);
        end
      end
    end
    if ((m_axis_tvalid_o && m_axis_tready_i) || (s_axis_tvalid_i && s_axis_tready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < IdleLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  task automatic send_request(input logic [KindW-1:0] kind, input logic [ValueW-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {{PadW{1'b0}}, value, kind};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_text(kind, value);
    requests_sent++;
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] v;
    int p;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 99);
      2: begin
        v = 1;
        p = $urandom_range(0, 9);
        for (int k = 0; k < p; k++) v = v * 10;
        v = v - $urandom_range(0, 1);
      end
      default: v = -$urandom_range(1, 1000);
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_request(KIND_CHAR, 32'h0000_0000);
    send_request(KIND_CHAR, 32'h0000_00FF);
    send_request(KIND_CHAR, 32'hFFFF_FF41);
    send_request(KIND_UDEC, 32'd0);
    send_request(KIND_UDEC, 32'd9);
    send_request(KIND_UDEC, 32'd10);
    send_request(KIND_UDEC, 32'hFFFF_FFFF);
    send_request(KIND_SDEC, 32'd0);
    send_request(KIND_SDEC, 32'd1);
    send_request(KIND_SDEC, 32'h7FFF_FFFF);
    send_request(KIND_SDEC, 32'h8000_0000);
    send_request(KIND_SDEC, 32'hFFFF_FFFF);
    send_request(KIND_SDEC, 32'hFFFF_FFF6);
    send_request(KIND_OCT, 32'd0);
    send_request(KIND_OCT, 32'd7);
    send_request(KIND_OCT, 32'd8);
    send_request(KIND_OCT, 32'hFFFF_FFFF);
    send_request(KIND_HEX, 32'd0);
    send_request(KIND_HEX, 32'h0000_000F);
    send_request(KIND_HEX, 32'h0000_0010);
    send_request(KIND_HEX, 32'hDEAD_BEEF);
    send_request(KIND_HEX, 32'hFFFF_FFFF);
    send_request(KIND_HELLO, 32'h1234_5678);
    send_request(KIND_RSVD6, 32'h0);
    send_request(KIND_RSVD7, 32'hFFFF_FFFF);
  endtask

  task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
    logic [KindW-1:0] kind;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) kind = KindW'($urandom_range(KIND_HELLO, KIND_RSVD7));
      else kind = KindW'($urandom_range(KIND_CHAR, KIND_HEX));
      send_request(kind, random_value());
    end
  endtask

  task automatic test_no_idle();
    run_random_phase(100, 0, 0);
  endtask

  task automatic test_sender_idle();
    run_random_phase(100, 53, 0);
  endtask

  task automatic test_receiver_stall();
    run_random_phase(100, 0, 53);
  endtask

  task automatic test_both_idle();
    run_random_phase(100, 32, 32);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idle();
    wait_for_drain();
    test_sender_idle();
    test_receiver_stall();
    wait_for_drain();
    test_both_idle();
    wait_for_drain();
    $display("Ran %0d requests over all directive kinds, %0d characters checked,",
             requests_sent, chars_checked);
    $display("with sender gaps, receiver stalls and drain pauses in four phases.");
    if (char_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
